>>> rtl/core/assert_macros.svh
// Assertion helpers used by the RTL checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define WB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Checked at every edge, reset included.
`define WB_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

>>> rtl/core/wwb_pkg.sv
package wwb_pkg;

    localparam int MAX_RADIUS_DEF = 8;
    localparam int MAX_COLS_DEF   = 2048;
    localparam int MAX_ROWS_DEF   = 4096;

    localparam int PIX_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int RAD_REG_W  = 4;
    localparam int ROWS_REG_W = 13;
    localparam int COLS_REG_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 2'd2;

    localparam logic [RAD_REG_W-1:0]  RADIUS_RST = 4'd8;
    localparam logic [ROWS_REG_W-1:0] ROWS_RST   = 13'd1920;
    localparam logic [COLS_REG_W-1:0] COLS_RST   = 12'd2048;

    localparam logic KIND_PIXEL = 1'b0;

endpackage

>>> rtl/core/weighted_window_blur_rgb.sv
// Weighted window blur over an RGB frame streamed in raster order. Each result
// pixel is formed in the back end from every in-frame window tap, up to
// (2R+1)^2 taps and a single tap at R=0, read through the line memory's
// single read port, which delivers one tap per cycle. The front end writes
// pixels into the line memory and queues output jobs, so input keeps flowing
// until two jobs wait; results lag the input by R*cols+R pixels and drain
// items push out the tail of the frame. No clearing pass is needed after
// reset. Writes to the radius, rows or cols register restart the frame.
module weighted_window_blur_rgb #(
    parameter int MAX_RADIUS = wwb_pkg::MAX_RADIUS_DEF,
    parameter int MAX_COLS   = wwb_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS   = wwb_pkg::MAX_ROWS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [wwb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wwb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_kind,
    input  logic [wwb_pkg::PIX_W-1:0]      i_red_in,
    input  logic [wwb_pkg::PIX_W-1:0]      i_green_in,
    input  logic [wwb_pkg::PIX_W-1:0]      i_blue_in,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [wwb_pkg::PIX_W-1:0]      o_red_out,
    output logic [wwb_pkg::PIX_W-1:0]      o_green_out,
    output logic [wwb_pkg::PIX_W-1:0]      o_blue_out,
    output logic                           o_frame_end
);
    import wwb_pkg::*;

    localparam int RADW  = $clog2(MAX_RADIUS + 1);
    localparam int ROWW  = $clog2(MAX_ROWS);
    localparam int COLW  = $clog2(MAX_COLS);
    localparam int ROWCW = $clog2(MAX_ROWS + 1);
    localparam int COLCW = $clog2(MAX_COLS + 1);
    localparam int DEPTH = (2 * MAX_RADIUS + 1) * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int JOBW  = 1 + AW + COLW + ROWW;

    logic               w_wr_en;
    logic [AW-1:0]      w_wr_addr;
    logic [3*PIX_W-1:0] w_wr_data;
    logic               w_push, w_pop, w_full, w_empty;
    logic [JOBW-1:0]    w_job_in, w_job_out;
    logic [RADW-1:0]    w_radius;
    logic [ROWCW-1:0]   w_rows;
    logic [COLCW-1:0]   w_cols;

    wwb_front #(
        .MAX_RADIUS(MAX_RADIUS), .MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_kind      (i_kind),
        .i_red_in    (i_red_in),
        .i_green_in  (i_green_in),
        .i_blue_in   (i_blue_in),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_push      (w_push),
        .o_job       (w_job_in),
        .i_q_full    (w_full),
        .o_radius    (w_radius),
        .o_rows      (w_rows),
        .o_cols      (w_cols)
    );

    wwb_queue #(.WIDTH(JOBW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job_in),
        .i_pop   (w_pop),
        .o_data  (w_job_out),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    wwb_back #(
        .MAX_RADIUS(MAX_RADIUS), .MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_radius    (w_radius),
        .i_rows      (w_rows),
        .i_cols      (w_cols),
        .i_wr_en     (w_wr_en),
        .i_wr_addr   (w_wr_addr),
        .i_wr_data   (w_wr_data),
        .i_q_empty   (w_empty),
        .i_job       (w_job_out),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out),
        .o_frame_end (o_frame_end)
    );
endmodule

>>> rtl/core/wwb_queue.sv
module wwb_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    // two-entry job queue between front and back
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_data;
                r_wp        <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule

>>> rtl/core/wwb_front.sv
module wwb_front #(
    parameter int MAX_RADIUS = 8,
    parameter int MAX_COLS   = 2048,
    parameter int MAX_ROWS   = 4096,
    localparam int RADW  = $clog2(MAX_RADIUS + 1),
    localparam int ROWW  = $clog2(MAX_ROWS),
    localparam int COLW  = $clog2(MAX_COLS),
    localparam int ROWCW = $clog2(MAX_ROWS + 1),
    localparam int COLCW = $clog2(MAX_COLS + 1),
    localparam int DEPTH = (2 * MAX_RADIUS + 1) * MAX_COLS,
    localparam int AW    = $clog2(DEPTH),
    localparam int JOBW  = 1 + AW + COLW + ROWW
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [wwb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [wwb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_kind,
    input  logic [wwb_pkg::PIX_W-1:0]        i_red_in,
    input  logic [wwb_pkg::PIX_W-1:0]        i_green_in,
    input  logic [wwb_pkg::PIX_W-1:0]        i_blue_in,
    output logic                             o_wr_en,
    output logic [AW-1:0]                    o_wr_addr,
    output logic [3*wwb_pkg::PIX_W-1:0]      o_wr_data,
    output logic                             o_push,
    output logic [JOBW-1:0]                  o_job,
    input  logic                             i_q_full,
    output logic [RADW-1:0]                  o_radius,
    output logic [ROWCW-1:0]                 o_rows,
    output logic [COLCW-1:0]                 o_cols
);
    import wwb_pkg::*;

    localparam int CNTW = $clog2(MAX_ROWS * MAX_COLS + 1);

    logic [RAD_REG_W-1:0]  r_radius;
    logic [ROWS_REG_W-1:0] r_rows;
    logic [COLS_REG_W-1:0] r_cols;

    logic [ROWW-1:0] r_in_row, n_in_row, r_out_row, n_out_row;
    logic [COLW-1:0] r_in_col, n_in_col, r_out_col, n_out_col;
    logic            r_full, n_full;
    logic [CNTW-1:0] r_rcv, n_rcv, r_out_cnt, n_out_cnt;
    logic [AW-1:0]   r_wr_addr, n_wr_addr, r_out_addr, n_out_addr;

    logic [ROWCW-1:0] w_rows;
    logic [COLCW-1:0] w_cols;
    logic [RADW-1:0]  w_rad;
    logic [CNTW-1:0]  w_rows_x, w_cols_x, w_rad_x, w_total, w_rcv_n;
    logic [CNTW:0]    w_lead, w_need, w_cap;
    logic             w_acc, w_pix, w_emit, w_last, w_cfg_wr;

    assign w_rad  = (32'(r_radius) > MAX_RADIUS) ? RADW'(MAX_RADIUS) : RADW'(r_radius);
    assign w_rows = (r_rows == '0) ? ROWCW'(1) :
                    (32'(r_rows) > MAX_ROWS) ? ROWCW'(MAX_ROWS) : ROWCW'(r_rows);
    assign w_cols = (r_cols == '0) ? COLCW'(1) :
                    (32'(r_cols) > MAX_COLS) ? COLCW'(MAX_COLS) : COLCW'(r_cols);

    assign o_radius = w_rad;
    assign o_rows   = w_rows;
    assign o_cols   = w_cols;

    assign w_rows_x = CNTW'(w_rows);
    assign w_cols_x = CNTW'(w_cols);
    assign w_rad_x  = CNTW'(w_rad);
    assign w_total  = w_rows_x * w_cols_x;
    assign w_lead   = (CNTW+1)'(w_rad_x * w_cols_x) + (CNTW+1)'(w_rad_x) + (CNTW+1)'(1);

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && (i_cfg_index == CFG_RADIUS ||
                         i_cfg_index == CFG_ROWS || i_cfg_index == CFG_COLS);

    assign o_ready = !i_q_full;
    assign w_acc   = i_valid && !i_q_full;
    assign w_pix   = w_acc && (i_kind == KIND_PIXEL) && !r_full;
    assign w_rcv_n = r_rcv + CNTW'(w_pix);
    assign w_need  = (CNTW+1)'(r_out_cnt) + w_lead;
    assign w_cap   = (w_need > (CNTW+1)'(w_total)) ? (CNTW+1)'(w_total) : w_need;
    assign w_emit  = w_acc && (r_out_cnt < w_total) && ((CNTW+1)'(w_rcv_n) >= w_cap);
    assign w_last  = (r_out_cnt == w_total - CNTW'(1));

    assign o_wr_en   = w_pix;
    assign o_wr_addr = r_wr_addr;
    assign o_wr_data = {i_red_in, i_green_in, i_blue_in};
    assign o_push    = w_emit;
    assign o_job     = {w_last, r_out_addr, r_out_col, r_out_row};

    always_comb begin
        n_in_row   = r_in_row;
        n_in_col   = r_in_col;
        n_full     = r_full;
        n_rcv      = w_rcv_n;
        n_wr_addr  = r_wr_addr;
        n_out_row  = r_out_row;
        n_out_col  = r_out_col;
        n_out_cnt  = r_out_cnt;
        n_out_addr = r_out_addr;
        if (w_pix) begin
            n_wr_addr = (r_wr_addr == AW'(DEPTH - 1)) ? '0 : r_wr_addr + AW'(1);
            if (COLCW'(r_in_col) + COLCW'(1) >= w_cols) begin
                n_in_col = '0;
                if (ROWCW'(r_in_row) + ROWCW'(1) >= w_rows) begin
                    n_in_row = '0;
                    n_full   = 1'b1;
                end else begin
                    n_in_row = r_in_row + ROWW'(1);
                end
            end else begin
                n_in_col = r_in_col + COLW'(1);
            end
        end
        if (w_emit) begin
            n_out_cnt  = r_out_cnt + CNTW'(1);
            n_out_addr = (r_out_addr == AW'(DEPTH - 1)) ? '0 : r_out_addr + AW'(1);
            if (COLCW'(r_out_col) + COLCW'(1) >= w_cols) begin
                n_out_col = '0;
                n_out_row = r_out_row + ROWW'(1);
            end else begin
                n_out_col = r_out_col + COLW'(1);
            end
        end
        if ((w_emit && w_last) || w_cfg_wr) begin
            n_in_row   = '0;
            n_in_col   = '0;
            n_full     = 1'b0;
            n_rcv      = '0;
            n_out_row  = '0;
            n_out_col  = '0;
            n_out_cnt  = '0;
            // the ring keeps rolling, so jobs of the old frame still in the
            // back end are not overwritten by the first pixels of the next one
            n_out_addr = n_wr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius   <= RADIUS_RST;
            r_rows     <= ROWS_RST;
            r_cols     <= COLS_RST;
            r_in_row   <= '0;
            r_in_col   <= '0;
            r_full     <= 1'b0;
            r_rcv      <= '0;
            r_wr_addr  <= '0;
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_out_cnt  <= '0;
            r_out_addr <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_RADIUS: r_radius <= i_cfg_data[RAD_REG_W-1:0];
                    CFG_ROWS:   r_rows   <= i_cfg_data[ROWS_REG_W-1:0];
                    CFG_COLS:   r_cols   <= i_cfg_data[COLS_REG_W-1:0];
                    default:    ;
                endcase
            end
            r_in_row   <= n_in_row;
            r_in_col   <= n_in_col;
            r_full     <= n_full;
            r_rcv      <= n_rcv;
            r_wr_addr  <= n_wr_addr;
            r_out_row  <= n_out_row;
            r_out_col  <= n_out_col;
            r_out_cnt  <= n_out_cnt;
            r_out_addr <= n_out_addr;
        end
    end
endmodule

>>> rtl/core/wwb_back.sv
module wwb_back #(
    parameter int MAX_RADIUS = 8,
    parameter int MAX_COLS   = 2048,
    parameter int MAX_ROWS   = 4096,
    localparam int RADW  = $clog2(MAX_RADIUS + 1),
    localparam int ROWW  = $clog2(MAX_ROWS),
    localparam int COLW  = $clog2(MAX_COLS),
    localparam int ROWCW = $clog2(MAX_ROWS + 1),
    localparam int COLCW = $clog2(MAX_COLS + 1),
    localparam int DEPTH = (2 * MAX_RADIUS + 1) * MAX_COLS,
    localparam int AW    = $clog2(DEPTH),
    localparam int JOBW  = 1 + AW + COLW + ROWW
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [RADW-1:0]             i_radius,
    input  logic [ROWCW-1:0]            i_rows,
    input  logic [COLCW-1:0]            i_cols,
    input  logic                        i_wr_en,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic [3*wwb_pkg::PIX_W-1:0] i_wr_data,
    input  logic                        i_q_empty,
    input  logic [JOBW-1:0]             i_job,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [wwb_pkg::PIX_W-1:0]   o_red_out,
    output logic [wwb_pkg::PIX_W-1:0]   o_green_out,
    output logic [wwb_pkg::PIX_W-1:0]   o_blue_out,
    output logic                        o_frame_end
);
    import wwb_pkg::*;

    localparam int WW   = 2 * RADW + 1;
    localparam int SWW  = WW + $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
    localparam int SRW  = SWW + PIX_W;
    localparam int RW2  = ((ROWCW > RADW) ? ROWCW : RADW) + 1;
    localparam int CW2  = ((COLCW > RADW) ? COLCW : RADW) + 1;
    localparam int QBW  = $clog2(PIX_W);

    typedef enum logic [2:0] {
        S_IDLE, S_SETUP, S_START, S_ACC, S_FLUSH, S_LOAD, S_DIV, S_OUT
    } t_state;

    t_state r_state;

    logic [3*PIX_W-1:0] r_mem [DEPTH];
    logic [3*PIX_W-1:0] r_rd;
    logic [AW-1:0]      r_addr, r_row_addr;

    logic [ROWW-1:0] r_orow, r_k, r_klo, r_khi;
    logic [COLW-1:0] r_ocol, r_l, r_llo, r_lhi;
    logic [AW-1:0]   r_oaddr, r_t;
    logic            r_last;

    logic            r_v1;
    logic [WW-1:0]   r_w1;
    logic [SRW-1:0]  r_sum [3];
    logic [SWW-1:0]  r_sw;
    logic [SRW-1:0]  r_rem [3];
    logic [PIX_W-1:0] r_q [3];
    logic [QBW-1:0]  r_bit;

    // window bounds, clipped to the frame
    logic [RW2-1:0] w_orow_e, w_rad_r, w_rows_e, w_klo, w_khi;
    logic [CW2-1:0] w_ocol_e, w_rad_c, w_cols_e, w_llo, w_lhi;
    logic [AW-1:0]  w_dr, w_dc, w_cols_a, w_t;
    logic [AW:0]    w_start, w_row_next;

    logic [ROWW-1:0] w_dk;
    logic [COLW-1:0] w_dl;
    logic [RADW-1:0] w_ak, w_al;
    logic [WW-1:0]   w_w;

    assign w_orow_e = RW2'(r_orow);
    assign w_rad_r  = RW2'(i_radius);
    assign w_rows_e = RW2'(i_rows);
    assign w_ocol_e = CW2'(r_ocol);
    assign w_rad_c  = CW2'(i_radius);
    assign w_cols_e = CW2'(i_cols);

    assign w_klo = (w_orow_e > w_rad_r) ? w_orow_e - w_rad_r : '0;
    assign w_khi = (w_orow_e + w_rad_r < w_rows_e - RW2'(1)) ? w_orow_e + w_rad_r
                                                             : w_rows_e - RW2'(1);
    assign w_llo = (w_ocol_e > w_rad_c) ? w_ocol_e - w_rad_c : '0;
    assign w_lhi = (w_ocol_e + w_rad_c < w_cols_e - CW2'(1)) ? w_ocol_e + w_rad_c
                                                             : w_cols_e - CW2'(1);

    assign w_cols_a = AW'(i_cols);
    assign w_dr     = AW'(w_orow_e - w_klo);
    assign w_dc     = AW'(w_ocol_e - w_llo);
    assign w_t      = w_dr * w_cols_a + w_dc;

    // ring address of the top-left tap: output address minus the window offset
    assign w_start    = (r_oaddr >= r_t) ? (AW+1)'(r_oaddr - r_t)
                                         : (AW+1)'(r_oaddr) + (AW+1)'(DEPTH) - (AW+1)'(r_t);
    assign w_row_next = (AW+1)'(r_row_addr) + (AW+1)'(w_cols_a);

    assign w_dk = (r_k >= r_orow) ? r_k - r_orow : r_orow - r_k;
    assign w_dl = (r_l >= r_ocol) ? r_l - r_ocol : r_ocol - r_l;
    assign w_ak = i_radius - RADW'(w_dk);
    assign w_al = i_radius - RADW'(w_dl);
    assign w_w  = WW'(w_ak) * WW'(w_ak) + WW'(w_al) * WW'(w_al) + WW'(1);

    assign o_pop = (r_state == S_IDLE) && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_v1    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v1 <= (r_state == S_ACC);
            r_w1 <= w_w;
            if (r_v1) begin
                for (int c = 0; c < 3; c++) begin
                    r_sum[c] <= r_sum[c] + SRW'(r_rd[PIX_W*(2-c) +: PIX_W]) * SRW'(r_w1);
                end
                r_sw <= r_sw + SWW'(r_w1);
            end
            if (o_valid && i_ready && r_state != S_OUT) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_orow  <= i_job[ROWW-1:0];
                        r_ocol  <= i_job[ROWW +: COLW];
                        r_oaddr <= i_job[ROWW+COLW +: AW];
                        r_last  <= i_job[JOBW-1];
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_klo   <= ROWW'(w_klo);
                    r_khi   <= ROWW'(w_khi);
                    r_llo   <= COLW'(w_llo);
                    r_lhi   <= COLW'(w_lhi);
                    r_t     <= w_t;
                    r_state <= S_START;
                end
                S_START: begin
                    r_k        <= r_klo;
                    r_l        <= r_llo;
                    r_addr     <= AW'(w_start);
                    r_row_addr <= AW'(w_start);
                    for (int c = 0; c < 3; c++) begin
                        r_sum[c] <= '0;
                    end
                    r_sw    <= '0;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    // one tap read per cycle, row by row
                    if (r_l == r_lhi) begin
                        if (r_k == r_khi) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_k <= r_k + ROWW'(1);
                            r_l <= r_llo;
                            if (w_row_next >= (AW+1)'(DEPTH)) begin
                                r_row_addr <= AW'(w_row_next - (AW+1)'(DEPTH));
                                r_addr     <= AW'(w_row_next - (AW+1)'(DEPTH));
                            end else begin
                                r_row_addr <= AW'(w_row_next);
                                r_addr     <= AW'(w_row_next);
                            end
                        end
                    end else begin
                        r_l    <= r_l + COLW'(1);
                        r_addr <= (r_addr == AW'(DEPTH - 1)) ? '0 : r_addr + AW'(1);
                    end
                end
                S_FLUSH: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    for (int c = 0; c < 3; c++) begin
                        r_rem[c] <= r_sum[c];
                        r_q[c]   <= '0;
                    end
                    r_bit   <= QBW'(PIX_W - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // restoring division; the quotient is a weighted mean, so 8 bits
                    for (int c = 0; c < 3; c++) begin
                        if (r_rem[c] >= (SRW'(r_sw) << r_bit)) begin
                            r_rem[c]      <= r_rem[c] - (SRW'(r_sw) << r_bit);
                            r_q[c][r_bit] <= 1'b1;
                        end
                    end
                    if (r_bit == '0) begin
                        r_state <= S_OUT;
                    end else begin
                        r_bit <= r_bit - QBW'(1);
                    end
                end
                S_OUT: begin
                    if (!o_valid || i_ready) begin
                        o_valid     <= 1'b1;
                        o_red_out   <= r_q[0];
                        o_green_out <= r_q[1];
                        o_blue_out  <= r_q[2];
                        o_frame_end <= r_last;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> rtl/core/wwb_checker.sv
`include "assert_macros.svh"

module wwb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_red_out,
    input logic [7:0] o_green_out,
    input logic [7:0] o_blue_out,
    input logic       o_frame_end
);
    // a stalled result transaction keeps its payload
    `WB_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_red_out) && $stable(o_green_out) && $stable(o_blue_out) && $stable(o_frame_end))
    // reset empties the output register
    `WB_ASSERT_ALWAYS(a_rst_clears, i_clk, !i_rst_n |=> !o_valid)
    // no result reaches the port right after leaving reset
    `WB_ASSERT_ALWAYS(a_rst_latency, i_clk, $rose(i_rst_n) |=> ##1 !o_valid)
endmodule

bind weighted_window_blur_rgb wwb_checker u_wwb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_red_out   (o_red_out),
    .o_green_out (o_green_out),
    .o_blue_out  (o_blue_out),
    .o_frame_end (o_frame_end)
);

>>> bench/wwb_checker.sv
`timescale 1ns / 1ps

module wwb_scoreboard
    import wwb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic                  i_kind,
    input  logic [PIX_W-1:0]      i_red,
    input  logic [PIX_W-1:0]      i_green,
    input  logic [PIX_W-1:0]      i_blue,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [PIX_W-1:0]      i_red_out,
    input  logic [PIX_W-1:0]      i_green_out,
    input  logic [PIX_W-1:0]      i_blue_out,
    input  logic                  i_frame_end,
    output int                    o_errors,
    output int                    o_pending
);

    localparam int RING_DEPTH = (2 * MAX_RADIUS_DEF + 1) * MAX_COLS_DEF;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             last;
    } blurred_px_t;

    logic [23:0]  ring [0:RING_DEPTH-1];
    blurred_px_t  blur_q[$];
    int unsigned  radius_reg, rows_reg, cols_reg;
    int unsigned  wr_row, wr_col, rd_row, rd_col;
    bit           frame_done;

    assign o_pending = blur_q.size();

    function automatic void restart_frame();
        wr_row = 0; wr_col = 0; rd_row = 0; rd_col = 0;
        frame_done = 0;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_RADIUS: radius_reg = val[RAD_REG_W-1:0];
            CFG_ROWS:   rows_reg   = val[ROWS_REG_W-1:0];
            CFG_COLS:   cols_reg   = val[COLS_REG_W-1:0];
            default:    return;
        endcase
        restart_frame();
    endfunction

    // One input item in, zero or one blurred pixel queued.
    function automatic void blur_step(logic kind, logic [7:0] r, logic [7:0] g,
                                      logic [7:0] b);
        int unsigned rad, nrows, ncols, total, rcv, pos, need;
        int unsigned klo, khi, llo, lhi, dk, dl, wrow, w;
        int unsigned sr, sg, sb, sw;
        logic [23:0] px;
        blurred_px_t res;
        rad   = radius_reg > MAX_RADIUS_DEF ? MAX_RADIUS_DEF : radius_reg;
        nrows = rows_reg < 1 ? 1 : (rows_reg > MAX_ROWS_DEF ? MAX_ROWS_DEF : rows_reg);
        ncols = cols_reg < 1 ? 1 : (cols_reg > MAX_COLS_DEF ? MAX_COLS_DEF : cols_reg);
        total = nrows * ncols;
        if (kind == KIND_PIXEL && !frame_done) begin
            ring[(wr_row * ncols + wr_col) % RING_DEPTH] = {r, g, b};
            wr_col++;
            if (wr_col >= ncols) begin
                wr_col = 0;
                wr_row++;
                if (wr_row >= nrows) begin
                    wr_row = 0;
                    frame_done = 1;
                end
            end
        end
        rcv  = frame_done ? total : wr_row * ncols + wr_col;
        pos  = rd_row * ncols + rd_col;
        need = pos + rad * ncols + rad + 1;
        if (need > total) need = total;
        if (rcv < need || pos >= total) return;
        klo = rd_row > rad ? rd_row - rad : 0;
        khi = rd_row + rad < nrows - 1 ? rd_row + rad : nrows - 1;
        llo = rd_col > rad ? rd_col - rad : 0;
        lhi = rd_col + rad < ncols - 1 ? rd_col + rad : ncols - 1;
        sr = 0; sg = 0; sb = 0; sw = 0;
        for (int unsigned k = klo; k <= khi; k++) begin
            dk   = k > rd_row ? k - rd_row : rd_row - k;
            wrow = (rad - dk) * (rad - dk) + 1;
            for (int unsigned l = llo; l <= lhi; l++) begin
                px = ring[(k * ncols + l) % RING_DEPTH];
                dl = l > rd_col ? l - rd_col : rd_col - l;
                w  = wrow + (rad - dl) * (rad - dl);
                sr += px[23:16] * w;
                sg += px[15:8] * w;
                sb += px[7:0] * w;
                sw += w;
            end
        end
        if (sw == 0) sw = 1;
        res.red   = 8'(sr / sw);
        res.green = 8'(sg / sw);
        res.blue  = 8'(sb / sw);
        res.last  = (pos == total - 1);
        blur_q.push_back(res);
        if (res.last) begin
            restart_frame();
        end else begin
            rd_col++;
            if (rd_col >= ncols) begin
                rd_col = 0;
                rd_row++;
            end
        end
    endfunction

    always @(posedge i_clk) begin
        blurred_px_t exp_px;
        if (!i_rst_n) begin
            radius_reg = RADIUS_RST;
            rows_reg   = ROWS_RST;
            cols_reg   = COLS_RST;
            restart_frame();
            blur_q.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                apply_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && i_in_ready)
                blur_step(i_kind, i_red, i_green, i_blue);
            if (i_out_valid && i_out_ready) begin
                if (blur_q.size() == 0) begin
                    $error("unexpected result transaction");
                    o_errors <= o_errors + 1;
                end else begin
                    exp_px = blur_q.pop_front();
                    if (exp_px != {i_red_out, i_green_out, i_blue_out, i_frame_end})
                        o_errors <= o_errors + 1;
                    if (exp_px.red != i_red_out)
                        $error("red_out: expected %0d, got %0d", exp_px.red, i_red_out);
                    if (exp_px.green != i_green_out)
                        $error("green_out: expected %0d, got %0d", exp_px.green,
                               i_green_out);
                    if (exp_px.blue != i_blue_out)
                        $error("blue_out: expected %0d, got %0d", exp_px.blue, i_blue_out);
                    if (exp_px.last != i_frame_end)
                        $error("frame_end: expected %0d, got %0d", exp_px.last,
                               i_frame_end);
                end
            end
        end
    end

endmodule

>>> bench/tb_weighted_window_blur_rgb.sv
`timescale 1ns / 1ps

module tb_weighted_window_blur_rgb;
    import wwb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                  i_clk, i_rst_n;
    logic                  i_cfg_valid, o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid, o_ready, i_kind;
    logic [PIX_W-1:0]      i_red_in, i_green_in, i_blue_in;
    logic                  o_valid, i_ready;
    logic [PIX_W-1:0]      o_red_out, o_green_out, o_blue_out;
    logic                  o_frame_end;
    int                    errors, pending, cycle_cnt, items_sent;
    bit                    calm;

    weighted_window_blur_rgb dut (.*);

    wwb_scoreboard u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_valid), .i_in_ready(o_ready), .i_kind(i_kind),
        .i_red(i_red_in), .i_green(i_green_in), .i_blue(i_blue_in),
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_red_out(o_red_out), .i_green_out(o_green_out), .i_blue_out(o_blue_out),
        .i_frame_end(o_frame_end), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #30ms;
        $display("weighted_window_blur_rgb test failed");
        $finish;
    end

    // Long stall-free stretch, recurring periodically.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        calm      <= (cycle_cnt % 20000) < 3000;
        i_ready   <= calm || $urandom_range(99) >= 17;
    end

    task automatic gap_cycles();
        while (!calm && $urandom_range(99) < 17) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
    endtask

    task automatic send_item(logic kind, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        gap_cycles();
        i_valid    <= 1;
        i_kind     <= kind;
        i_red_in   <= r;
        i_green_in <= g;
        i_blue_in  <= b;
        @(negedge i_clk);
        while (!o_ready) @(negedge i_clk);
        @(posedge i_clk);
        if (kind == KIND_PIXEL) items_sent++;
    endtask

    task automatic send_rand_pixel();
        send_item(KIND_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic wait_idle();
        i_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (320) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_valid <= 0;
    endtask

    // Upper data bits beyond a register's width get random junk.
    task automatic set_frame(int rad, int nrows, int ncols);
        write_reg(CFG_RADIUS, 13'(rad) | 13'($urandom << RAD_REG_W));
        write_reg(CFG_ROWS, 13'(nrows));
        write_reg(CFG_COLS, 13'(ncols) | 13'($urandom << COLS_REG_W));
    endtask

    // Full frame: pixels with stray early drains, then tail items to flush.
    // A broken frame stops after a short random number of pixels.
    task automatic blur_frame(int rad, int nrows, int ncols, bit broken);
        int er, erows, ecols, total, lag, tail, cut;
        er    = rad > MAX_RADIUS_DEF ? MAX_RADIUS_DEF : rad;
        erows = nrows < 1 ? 1 : (nrows > MAX_ROWS_DEF ? MAX_ROWS_DEF : nrows);
        ecols = ncols < 1 ? 1 : (ncols > MAX_COLS_DEF ? MAX_COLS_DEF : ncols);
        total = erows * ecols;
        lag   = er * ecols + er;
        tail  = total - ((total - lag) > 1 ? total - lag : 1);
        cut   = broken ? $urandom_range(total > 64 ? 63 : total - 1) : total;
        set_frame(rad, nrows, ncols);
        for (int i = 0; i < cut; i++) begin
            if ($urandom_range(9) == 0)
                send_item(!KIND_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
            send_rand_pixel();
        end
        if (!broken)
            for (int i = 0; i < tail; i++)
                send_item(1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        wait_idle();
    endtask

    initial begin
        i_rst_n     = 0;
        i_cfg_valid = 0;
        i_cfg_index = CFG_RADIUS;
        i_cfg_data  = 0;
        i_valid     = 0;
        i_kind      = KIND_PIXEL;
        i_red_in    = 0;
        i_green_in  = 0;
        i_blue_in   = 0;
        i_ready     = 0;
        cycle_cnt   = 0;
        calm        = 0;
        items_sent  = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: 3x4 frame, R=1, extreme channel values, early drain.
        set_frame(1, 3, 4);
        send_item(!KIND_PIXEL, 8'hff, 8'hff, 8'hff);
        for (int i = 0; i < 12; i++)
            send_item(KIND_PIXEL, (i % 2) ? 8'hff : 8'h00, (i % 3) ? 8'h00 : 8'hff,
                      (i < 6) ? 8'hff : 8'h00);
        send_item(KIND_PIXEL, 8'hff, 8'h00, 8'hff);
        repeat (4) send_item(!KIND_PIXEL, 8'h00, 8'hff, 8'h00);
        wait_idle();
        // Zero-sized frame registers clamp to 1x1; radius 0.
        set_frame(0, 0, 0);
        send_item(KIND_PIXEL, 8'hff, 8'hff, 8'hff);
        send_item(KIND_PIXEL, 8'h00, 8'h00, 8'h00);
        wait_idle();
        write_reg(CFG_UNUSED, 13'h1fff);
        // Clamped radius on a tall frame, out-of-range size registers.
        blur_frame(15, 40, 1, 0);
        blur_frame(8, 1, 4095, 1);
        blur_frame(8, 8191, 1, 1);

        while (items_sent < 700) begin
            if ($urandom_range(3) == 0)
                blur_frame($urandom_range(15), $urandom_range(8), $urandom_range(10), 1);
            else
                blur_frame($urandom_range(8), $urandom_range(1, 6),
                           $urandom_range(1, 8), 0);
        end

        wait_idle();
        if (errors == 0)
            $display("weighted_window_blur_rgb test passed");
        else
            $display("weighted_window_blur_rgb test failed");
        $finish;
    end

endmodule
